FILE: rtl/core/rtm_pkg.sv
// Shared codes, constants, the stage control type and record check for the run-time meter.
package rtm_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_RESTORE = 2'd2;

   localparam logic [2:0] SRC_NOT_RESTORE = 3'd0;
   localparam logic [2:0] SRC_BOTH        = 3'd1;
   localparam logic [2:0] SRC_PRIMARY     = 3'd2;
   localparam logic [2:0] SRC_BACKUP      = 3'd3;
   localparam logic [2:0] SRC_LEGACY      = 3'd4;
   localparam logic [2:0] SRC_EMPTY       = 3'd5;

   localparam logic [31:0] REC_MAGIC = 32'h5449_4D52;
   localparam logic [31:0] REC_SALT  = 32'hA5A5_5A5A;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   // seconds ^ ~seconds is all ones, so the checksum of a written record is fixed
   localparam logic [31:0] REC_CHECK = REC_MAGIC ^ ALL_ONES ^ REC_SALT;

   localparam logic [16:0] INTERVAL_RESET = 17'd900;
   localparam logic [10:0] MS_PER_S       = 11'd1000;

   // floor(n / 1000) == (n * RECIP) >> RECIP_SHIFT for every 32-bit n
   localparam logic [28:0] RECIP       = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  src;
      logic [31:0] rest_secs;
   } ctl_type;

   function automatic logic rec_ok(input logic [31:0] magic, input logic [31:0] secs,
                                   input logic [31:0] inv, input logic [31:0] chk);
      rec_ok = (magic == REC_MAGIC) && (inv == ~secs) &&
               (chk == (magic ^ secs ^ inv ^ REC_SALT));
   endfunction

endpackage

FILE: rtl/core/rtm_front.sv
// Input register: tick delta, divider operand selection and record validation.
module rtm_front import rtm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [1:0]    op,
   input  logic [31:0]   now_ms,
   input  logic [31:0]   pm,
   input  logic [31:0]   ps,
   input  logic [31:0]   pi,
   input  logic [31:0]   pc,
   input  logic [31:0]   bm,
   input  logic [31:0]   bs,
   input  logic [31:0]   bi,
   input  logic [31:0]   bc,
   input  logic          advance,
   output logic          s1_valid,
   output ctl_type       s1_ctl,
   output logic [31:0]   s1_operand
);

   logic [31:0] last_ms_ff, last_ms_in;
   logic        valid_ff, valid_in;
   ctl_type     ctl_ff, ctl_in;
   logic [31:0] operand_ff, operand_in;
   logic        pv, bv;

   always_comb begin
      pv = rec_ok(pm, ps, pi, pc);
      bv = rec_ok(bm, bs, bi, bc);
      ctl_in.op        = op;
      ctl_in.src       = SRC_NOT_RESTORE;
      ctl_in.rest_secs = '0;
      if (op == OP_RESTORE) begin
         if (pv && bv) begin
            ctl_in.src       = SRC_BOTH;
            ctl_in.rest_secs = (ps > bs) ? ps : bs;
         end else if (pv) begin
            ctl_in.src       = SRC_PRIMARY;
            ctl_in.rest_secs = ps;
         end else if (bv) begin
            ctl_in.src       = SRC_BACKUP;
            ctl_in.rest_secs = bs;
         end else if (pm != ALL_ONES && pm != '0) begin
            ctl_in.src = SRC_LEGACY;
         end else begin
            ctl_in.src = SRC_EMPTY;
         end
      end
      // restore divides the legacy word, everything else the tick gap
      operand_in = (op == OP_RESTORE) ? pm : (now_ms - last_ms_ff);
      last_ms_in = last_ms_ff;
      if (accept && (op == OP_TICK || op == OP_CLEAR || op == OP_RESTORE)) begin
         last_ms_in = now_ms;
      end
      valid_in = advance ? accept : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         last_ms_ff <= last_ms_in;
         valid_ff   <= valid_in;
      end
      if (accept) begin
         ctl_ff     <= ctl_in;
         operand_ff <= operand_in;
      end
   end

   assign s1_valid   = valid_ff;
   assign s1_ctl     = ctl_ff;
   assign s1_operand = operand_ff;

endmodule

FILE: rtl/core/rtm_div1k.sv
// Two-stage constant divide by 1000 using a reciprocal multiply.
module rtm_div1k import rtm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          s1_valid,
   input  ctl_type       s1_ctl,
   input  logic [31:0]   s1_operand,
   output logic          s3_valid,
   output ctl_type       s3_ctl,
   output logic [22:0]   s3_quot,
   output logic [9:0]    s3_rem
);

   logic        v2_ff, v3_ff;
   ctl_type     ctl2_ff, ctl3_ff;
   logic [31:0] opnd2_ff;
   logic [60:0] prod_ff, prod_in;
   logic [22:0] quot_ff, quot_in;
   logic [9:0]  rem_ff, rem_in;
   logic [32:0] back;

   always_comb begin
      prod_in = 61'(s1_operand) * 61'(RECIP);
      quot_in = prod_ff[60:RECIP_SHIFT];
      back    = 33'(quot_in) * 33'(MS_PER_S);
      rem_in  = 10'(33'(opnd2_ff) - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= s1_valid;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         prod_ff  <= prod_in;
         opnd2_ff <= s1_operand;
         ctl2_ff  <= s1_ctl;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         ctl3_ff  <= ctl2_ff;
      end
   end

   assign s3_valid = v3_ff;
   assign s3_ctl   = ctl3_ff;
   assign s3_quot  = quot_ff;
   assign s3_rem   = rem_ff;

endmodule

FILE: rtl/core/rtm_core.sv
// Meter state update and result register.
module rtm_core import rtm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [16:0]   interval,
   input  logic          s3_valid,
   input  ctl_type       s3_ctl,
   input  logic [22:0]   s3_quot,
   input  logic [9:0]    s3_rem,
   output logic          out_valid,
   output logic [31:0]   out_seconds,
   output logic          out_save,
   output logic [2:0]    out_src
);

   logic [31:0] total_ff, total_in;
   logic [9:0]  remain_ff, remain_in;
   logic [16:0] unsaved_ff, unsaved_in;
   logic        valid_ff;
   logic [31:0] seconds_ff;
   logic        save_ff, save_in;
   logic [2:0]  src_ff;
   logic [10:0] ms_sum;
   logic        carry;
   logic [31:0] secs;
   logic [32:0] uns;

   always_comb begin
      ms_sum     = 11'(s3_rem) + 11'(remain_ff);
      carry      = ms_sum >= MS_PER_S;
      secs       = 32'(s3_quot) + 32'(carry);
      uns        = 33'(unsaved_ff) + 33'(secs);
      total_in   = total_ff;
      remain_in  = remain_ff;
      unsaved_in = unsaved_ff;
      save_in    = 1'b0;
      case (s3_ctl.op)
         OP_TICK: begin
            remain_in = carry ? 10'(ms_sum - MS_PER_S) : ms_sum[9:0];
            if (secs != '0) begin
               total_in = total_ff + secs;
               if (uns >= 33'(interval)) begin
                  save_in    = 1'b1;
                  unsaved_in = '0;
               end else begin
                  unsaved_in = uns[16:0];
               end
            end
         end
         OP_CLEAR: begin
            total_in   = '0;
            remain_in  = '0;
            unsaved_in = '0;
            save_in    = 1'b1;
         end
         OP_RESTORE: begin
            if (s3_ctl.src == SRC_LEGACY) begin
               total_in = 32'(s3_quot);
               save_in  = 1'b1;
            end else begin
               total_in = s3_ctl.rest_secs;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         remain_ff  <= '0;
         unsaved_ff <= '0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         valid_ff <= s3_valid;
         if (s3_valid) begin
            total_ff   <= total_in;
            remain_ff  <= remain_in;
            unsaved_ff <= unsaved_in;
         end
      end
      if (advance && s3_valid) begin
         seconds_ff <= total_in;
         save_ff    <= save_in;
         src_ff     <= s3_ctl.src;
      end
   end

   assign out_valid   = valid_ff;
   assign out_seconds = seconds_ff;
   assign out_save    = save_ff;
   assign out_src     = src_ff;

endmodule

FILE: rtl/core/run_time_meter_with_checked_record.sv
// Top level of the elapsed run-time meter with checksummed persistence record.
//
// Usage:
//   req_* carries one transaction per item: a tick (operation 0) with the
//   free-running millisecond count, a meter reset (1), or a restore (2) that
//   also carries the primary and backup stored records. rsp_* returns exactly
//   one transaction per request: the seconds total, a save flag, the record
//   words to store in both copies, and which source a restore used.
//   csr_wr_en / csr_wr_data set the save interval in seconds; write it only
//   while no transaction is in flight.
// Stages: input register, reciprocal multiply, quotient/remainder and state
//   update, in that order from request acceptance to response valid.
// Throughput: one transaction per cycle when not stalled; the gap divide by 1000
//   runs ahead of the state stage, which only folds in the sub-second remainder.
// Reset: clears the total, remainder, unsaved count, last millisecond count
//   and all pipeline valids; the save interval returns to 900 seconds.
// Stall: when rsp_tready is low with a response pending, the whole pipeline
//   holds and req_tready drops; no transaction is lost or repeated.
module run_time_meter_with_checked_record import rtm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // req_tdata, low to high: now_ms, primary_magic, primary_seconds,
   // primary_inverted, primary_check, backup_magic, backup_seconds,
   // backup_inverted, backup_check
   input  logic [287:0]   req_tdata,
   // req_tuser: operation
   input  logic [1:0]     req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // rsp_tdata, low to high: run_seconds, record_magic, record_inverted,
   // record_check
   output logic [127:0]   rsp_tdata,
   // rsp_tuser, low to high: save_now, restore_source
   output logic [3:0]     rsp_tuser,
   input  logic           csr_wr_en,
   input  logic [16:0]    csr_wr_data
);

   logic [16:0] interval_ff;
   logic        advance;
   logic        accept;
   logic        s1_valid, s3_valid;
   ctl_type     s1_ctl, s3_ctl;
   logic [31:0] s1_operand;
   logic [22:0] s3_quot;
   logic [9:0]  s3_rem;
   logic [31:0] out_seconds;
   logic        out_save;
   logic [2:0]  out_src;

   // advance every stage together whenever the response slot frees up
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   rtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (req_tuser),
      .now_ms     (req_tdata[31:0]),
      .pm         (req_tdata[63:32]),
      .ps         (req_tdata[95:64]),
      .pi         (req_tdata[127:96]),
      .pc         (req_tdata[159:128]),
      .bm         (req_tdata[191:160]),
      .bs         (req_tdata[223:192]),
      .bi         (req_tdata[255:224]),
      .bc         (req_tdata[287:256]),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_operand (s1_operand)
   );

   rtm_div1k u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_operand (s1_operand),
      .s3_valid   (s3_valid),
      .s3_ctl     (s3_ctl),
      .s3_quot    (s3_quot),
      .s3_rem     (s3_rem)
   );

   rtm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .interval    (interval_ff),
      .s3_valid    (s3_valid),
      .s3_ctl      (s3_ctl),
      .s3_quot     (s3_quot),
      .s3_rem      (s3_rem),
      .out_valid   (rsp_tvalid),
      .out_seconds (out_seconds),
      .out_save    (out_save),
      .out_src     (out_src)
   );

   // record words follow directly from the seconds total
   assign rsp_tdata = {REC_CHECK, ~out_seconds, REC_MAGIC, out_seconds};
   assign rsp_tuser = {out_src, out_save};

   // a restore saves only when it fell back to the legacy word
   a_restore_save : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_save && out_src != SRC_NOT_RESTORE) |-> out_src == SRC_LEGACY)
      else $error("restore save without legacy source");

   // nothing usable restores to zero seconds
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_src == SRC_EMPTY) |-> out_seconds == '0)
      else $error("empty restore with nonzero total");

   // a stalled response keeps its seconds total
   a_hold_total : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(out_seconds) && $stable(out_src))
      else $error("response changed while stalled");

endmodule

FILE: bench/run_time_meter_with_checked_record_tb.sv
// Self-checking testbench for the run-time meter: directed and random traffic against a predictor.
module run_time_meter_with_checked_record_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtm_pkg::*;

   // operation code 3 has no meaning; the block passes it through as a no-op
   localparam logic [1:0]  OP_UNUSED        = 2'd3;
   localparam logic [63:0] MS_PER_SECOND    = 64'd1000;
   localparam logic [16:0] INTERVAL_DAY     = 17'd86400;
   localparam logic [16:0] INTERVAL_MAX     = 17'h1FFFF;
   localparam int          PHASE_COUNT      = 8;
   localparam int          PHASE_ITEMS      = 175;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          DRAIN_CYCLES     = 10;
   localparam int          CYCLE_LIMIT      = 200000;

   // one stored copy, low to high: magic, seconds, inverted, check
   typedef struct packed {
      logic [31:0] check;
      logic [31:0] inverted;
      logic [31:0] seconds;
      logic [31:0] magic;
   } stored_record_type;

   // laid out exactly as req_tdata: now_ms lowest, then primary, then backup
   typedef struct packed {
      stored_record_type backup;
      stored_record_type primary;
      logic [31:0]       now_ms;
   } meter_request_type;

   // laid out as {rsp_tuser, rsp_tdata}
   typedef struct packed {
      logic [2:0]  src;
      logic        save_now;
      logic [31:0] check;
      logic [31:0] inverted;
      logic [31:0] magic;
      logic [31:0] run_seconds;
   } meter_reading_type;

   typedef enum int {KIND_GOOD, KIND_DAMAGED, KIND_NOISE} record_kind_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         csr_wr_en;
   logic [16:0]  csr_wr_data;

   run_time_meter_with_checked_record u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: the meter as the block should hold it.
   logic [31:0] meter_seconds;
   logic [31:0] meter_rem_ms;
   logic [31:0] meter_last_ms;
   logic [31:0] meter_unsaved;
   logic [16:0] meter_interval;

   // Readings owed by the block, oldest first.
   meter_reading_type pending_readings[$];

   int mismatch_count = 0;
   int saves_seen     = 0;
   int op_count[4]    = '{default: 0};
   int source_count[6] = '{default: 0};

   // Knobs shared between the stimulus and the response sink.
   int          req_gap_max   = 7;
   int          rsp_gap_max   = 7;
   bit          long_hold_req = 1'b0;
   logic [31:0] dial_ms       = '0;   // millisecond count last offered to the block

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A stored copy counts only if the magic matches, the inverse is exact and
   // the checksum agrees; with an exact inverse the checksum reduces to ~(magic ^ salt).
   function automatic logic record_valid(input stored_record_type rec);
      return (rec.magic == REC_MAGIC) && ((rec.seconds ^ rec.inverted) == 32'hFFFF_FFFF) &&
             (rec.check == ~(rec.magic ^ REC_SALT));
   endfunction

   // Apply one transaction to the predictor state and return the reading it owes.
   function automatic meter_reading_type advance_meter(input logic [1:0] op,
                                                       input meter_request_type req);
      meter_reading_type rd;
      logic [31:0]       gap_ms;
      logic [63:0]       acc_ms, whole_s, rem_ms, unsaved_sum;
      logic              primary_ok, backup_ok;
      rd = '0;
      case (op)
         OP_TICK: begin
            // wrapped difference, then widen so a huge gap cannot overflow
            gap_ms        = req.now_ms - meter_last_ms;
            acc_ms        = {32'd0, meter_rem_ms} + {32'd0, gap_ms};
            meter_last_ms = req.now_ms;
            if (acc_ms >= MS_PER_SECOND) begin
               whole_s       = acc_ms / MS_PER_SECOND;
               rem_ms        = acc_ms % MS_PER_SECOND;
               meter_rem_ms  = rem_ms[31:0];
               meter_seconds = meter_seconds + whole_s[31:0];
               unsaved_sum   = {32'd0, meter_unsaved} + whole_s;
               if (unsaved_sum >= {47'd0, meter_interval}) begin
                  rd.save_now   = 1'b1;
                  meter_unsaved = '0;
               end else begin
                  meter_unsaved = unsaved_sum[31:0];
               end
            end else begin
               meter_rem_ms = acc_ms[31:0];
            end
         end
         OP_CLEAR: begin
            meter_seconds = '0;
            meter_rem_ms  = '0;
            meter_unsaved = '0;
            meter_last_ms = req.now_ms;
            rd.save_now   = 1'b1;
         end
         OP_RESTORE: begin
            primary_ok = record_valid(req.primary);
            backup_ok  = record_valid(req.backup);
            if (primary_ok && backup_ok) begin
               meter_seconds = (req.primary.seconds > req.backup.seconds) ?
                               req.primary.seconds : req.backup.seconds;
               rd.src = SRC_BOTH;
            end else if (primary_ok) begin
               meter_seconds = req.primary.seconds;
               rd.src = SRC_PRIMARY;
            end else if (backup_ok) begin
               meter_seconds = req.backup.seconds;
               rd.src = SRC_BACKUP;
            end else if (req.primary.magic != 32'd0 && req.primary.magic != 32'hFFFF_FFFF) begin
               // old firmware kept plain milliseconds in the first word
               meter_seconds = req.primary.magic / 32'd1000;
               rd.save_now   = 1'b1;
               rd.src        = SRC_LEGACY;
            end else begin
               meter_seconds = '0;
               rd.src        = SRC_EMPTY;
            end
            meter_last_ms = req.now_ms;
         end
         default: ;
      endcase
      rd.run_seconds = meter_seconds;
      rd.magic       = REC_MAGIC;
      rd.inverted    = ~meter_seconds;
      rd.check       = REC_MAGIC ^ meter_seconds ^ ~meter_seconds ^ REC_SALT;
      return rd;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want_v,
                                input logic [31:0] seen_v);
      if (seen_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, seen_v);
         mismatch_count++;
      end
   endtask

   // Track every accepted request and every accepted response on the same edge
   // that the block sees them; push before pop so a same-edge pair stays in order.
   always @(posedge clock) begin : scoreboard
      meter_reading_type want, seen;
      if (reset) begin
         meter_seconds  = '0;
         meter_rem_ms   = '0;
         meter_last_ms  = '0;
         meter_unsaved  = '0;
         meter_interval = INTERVAL_RESET;
      end else begin
         if (csr_wr_en)
            meter_interval = csr_wr_data;
         if (req_tvalid && req_tready) begin
            want = advance_meter(req_tuser, meter_request_type'(req_tdata));
            pending_readings.push_back(want);
            op_count[req_tuser]++;
            if (req_tuser == OP_RESTORE)
               source_count[want.src]++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = meter_reading_type'({rsp_tuser, rsp_tdata});
            if (pending_readings.size() == 0) begin
               $display("%0t: response with nothing outstanding, expected none, actual %h",
                        $time, seen);
               mismatch_count++;
            end else begin
               want = pending_readings.pop_front();
               compare_field("run_seconds", want.run_seconds, seen.run_seconds);
               compare_field("save_now", {31'd0, want.save_now}, {31'd0, seen.save_now});
               compare_field("record_magic", want.magic, seen.magic);
               compare_field("record_inverted", want.inverted, seen.inverted);
               compare_field("record_check", want.check, seen.check);
               compare_field("restore_source", {29'd0, want.src}, {29'd0, seen.src});
               if (seen.save_now)
                  saves_seen++;
            end
         end
      end
   end

   // Response sink: stall a random number of cycles before each transaction, and
   // once on request hold off long enough to back the pipeline up into the input.
   initial begin : response_sink
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         stall = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   // Hard stop if the block wedges.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, CYCLE_LIMIT, pending_readings.size());
      $display("tb: failure");
      $finish;
   end

   // Offer one transaction and hold it until the block takes it. Call at a
   // rising edge; leave valid high so a back-to-back item needs no second write.
   task automatic send_item(input logic [1:0] op, input logic [31:0] now_ms,
                            input stored_record_type primary,
                            input stored_record_type backup);
      int                gap;
      meter_request_type req;
      req.now_ms  = now_ms;
      req.primary = primary;
      req.backup  = backup;
      dial_ms     = now_ms;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= req;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every owed reading has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic set_interval(input logic [16:0] seconds);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seconds;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic stored_record_type make_record(input record_kind_type kind,
                                                     input logic [31:0] seconds);
      stored_record_type rec;
      rec.magic    = REC_MAGIC;
      rec.seconds  = seconds;
      rec.inverted = ~seconds;
      rec.check    = REC_MAGIC ^ seconds ^ ~seconds ^ REC_SALT;
      // any single flipped bit breaks at least one of the three checks
      if (kind == KIND_DAMAGED)
         rec = rec ^ (128'd1 << $urandom_range(0, 127));
      else if (kind == KIND_NOISE)
         rec = {$urandom, $urandom, $urandom, $urandom};
      return rec;
   endfunction

   function automatic stored_record_type noise();
      return make_record(KIND_NOISE, '0);
   endfunction

   // Ticks across the second boundary and the 32-bit wrap, plus the no-op code
   // and a meter reset, all at the reset interval of 900 s.
   task automatic test_tick_basics();
      send_item(OP_TICK, 32'd0, '0, '0);                   // no time passed
      send_item(OP_TICK, 32'd999, noise(), noise());       // just short of a second
      send_item(OP_TICK, 32'd1000, noise(), noise());      // remainder tops up one second
      send_item(OP_TICK, 32'd0, noise(), noise());         // count wrapped: huge gap, save
      send_item(OP_TICK, 32'hFFFF_FFFF, noise(), noise()); // largest gap on a remainder
      send_item(OP_UNUSED, 32'hFFFF_FFFF, '1, '1);         // ignored, no state change
      send_item(OP_CLEAR, 32'hFFFF_FFFF, '1, '1);          // clear and save
      send_item(OP_TICK, 32'd500, noise(), noise());       // small gap across the wrap
      send_item(OP_TICK, 32'd1499, noise(), noise());      // carries the remainder over
   endtask

   // Every restore outcome, including the legacy word at its edges.
   task automatic test_restore_paths();
      stored_record_type legacy;
      send_item(OP_RESTORE, dial_ms + 10,
                make_record(KIND_GOOD, 32'hFFFF_FFFF), make_record(KIND_GOOD, 32'd0));
      send_item(OP_RESTORE, dial_ms + 10,
                make_record(KIND_GOOD, 32'd5), make_record(KIND_GOOD, 32'd7));
      send_item(OP_RESTORE, dial_ms + 10,
                make_record(KIND_GOOD, 32'd12345), make_record(KIND_GOOD, 32'd12345));
      send_item(OP_RESTORE, dial_ms + 10,
                make_record(KIND_GOOD, 32'd100), make_record(KIND_DAMAGED, 32'd200));
      send_item(OP_RESTORE, dial_ms + 10,
                make_record(KIND_DAMAGED, 32'd100), make_record(KIND_GOOD, 32'd300));
      legacy = noise();
      legacy.magic = 32'd1234567;
      send_item(OP_RESTORE, dial_ms + 10, legacy, noise());
      legacy.magic = 32'hFFFF_FFFE;                        // largest usable legacy word
      send_item(OP_RESTORE, dial_ms + 10, legacy, noise());
      legacy.magic = 32'd1;                                // legacy, rounds down to zero
      send_item(OP_RESTORE, dial_ms + 10, legacy, noise());
      legacy.magic = 32'd0;                                // blank storage
      send_item(OP_RESTORE, dial_ms + 10, legacy, noise());
      legacy.magic = 32'hFFFF_FFFF;                        // erased storage
      send_item(OP_RESTORE, dial_ms + 10, legacy, noise());
      send_item(OP_TICK, dial_ms + 1000, noise(), noise()); // counts from the restore point
   endtask

   // Interval at zero, at its widest and at one.
   task automatic test_interval_extremes();
      set_interval(17'd0);
      send_item(OP_TICK, dial_ms, noise(), noise());           // no whole second: no save
      send_item(OP_TICK, dial_ms + 1000, noise(), noise());    // any second saves
      set_interval(INTERVAL_MAX);
      send_item(OP_TICK, dial_ms + 32'd131070000, noise(), noise());
      send_item(OP_TICK, dial_ms + 32'd1000000, noise(), noise());
      set_interval(17'd1);
      send_item(OP_TICK, dial_ms + 1000, noise(), noise());
   endtask

   // Fill the pipeline while the sink holds off, so the input stalls.
   task automatic test_backpressure();
      wait_idle();
      req_gap_max   = 0;
      long_hold_req = 1'b1;
      repeat (40)
         send_item(OP_TICK, dial_ms + $urandom_range(0, 3000), noise(), noise());
      wait_idle();
      req_gap_max = 7;
   endtask

   task automatic send_random_tick();
      int          pick;
      logic [31:0] gap_ms;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         gap_ms = $urandom_range(0, 2500);
      else if (pick < 85)
         gap_ms = $urandom_range(0, 999);
      else if (pick < 93)
         gap_ms = $urandom_range(0, 200000);
      else if (pick < 97)
         gap_ms = $urandom;
      else
         gap_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);  // almost a full lap
      send_item(OP_TICK, dial_ms + gap_ms, noise(), noise());
   endtask

   // Mostly record pairs with at least one good copy, with the rest legacy, blank or noise.
   task automatic send_random_restore();
      stored_record_type primary, backup;
      logic [31:0]       secs_p, secs_b;
      int                pick;
      secs_p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom;
      secs_b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom;
      pick   = $urandom_range(0, 9);
      primary = make_record(KIND_GOOD, secs_p);
      backup  = make_record(KIND_GOOD, secs_b);
      case (pick)
         4: backup = make_record(KIND_DAMAGED, secs_b);
         5: primary = make_record(($urandom_range(0, 1) != 0) ? KIND_DAMAGED : KIND_NOISE,
                                  secs_p);
         6, 7: begin
            primary = make_record(KIND_DAMAGED, secs_p);
            backup  = make_record(KIND_DAMAGED, secs_b);
            primary.magic = $urandom;
         end
         8: begin
            primary = make_record(KIND_DAMAGED, secs_p);
            backup  = noise();
            primary.magic = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'hFFFF_FFFF;
         end
         9: begin
            primary = noise();
            backup  = noise();
         end
         default: ;
      endcase
      send_item(OP_RESTORE, ($urandom_range(0, 7) == 0) ? $urandom
                            : dial_ms + $urandom_range(0, 5000), primary, backup);
   endtask

   // Random traffic in phases, each under its own save interval.
   task automatic test_random_traffic();
      logic [16:0] phase_interval[PHASE_COUNT];
      int          pick, mode;
      phase_interval = '{17'd1, 17'd0, 17'd5, 17'd60, INTERVAL_RESET, INTERVAL_DAY,
                         INTERVAL_MAX, 17'd0};
      phase_interval[PHASE_COUNT - 1] = $urandom_range(1, 3600);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_interval(phase_interval[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // re-pick the idling mix now and then; one mix leaves both sides busy
            if (n % 25 == 0) begin
               mode = $urandom_range(0, 3);
               req_gap_max = (mode == 0 || mode == 2) ? 0 : 7;
               rsp_gap_max = (mode == 0 || mode == 3) ? 0 : 7;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
               send_random_tick();
            else if (pick < 83)
               send_item(OP_CLEAR, dial_ms + $urandom_range(0, 3000), noise(), noise());
            else if (pick < 97)
               send_random_restore();
            else
               send_item(OP_UNUSED, $urandom, noise(), noise());
         end
      end
      req_gap_max = 7;
      rsp_gap_max = 7;
   endtask

   initial begin : main_sequence
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_TICK;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_tick_basics();
      test_restore_paths();
      test_interval_extremes();
      test_backpressure();
      test_random_traffic();

      // let anything still in the pipeline surface before the verdict
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ticks, %0d meter resets, %0d restores, %0d no-op codes; %0d saves",
               op_count[OP_TICK], op_count[OP_CLEAR], op_count[OP_RESTORE],
               op_count[OP_UNUSED], saves_seen);
      $display("restores by source: both %0d, primary %0d, backup %0d, legacy %0d, none %0d",
               source_count[SRC_BOTH], source_count[SRC_PRIMARY], source_count[SRC_BACKUP],
               source_count[SRC_LEGACY], source_count[SRC_EMPTY]);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
